@@ src/bkm_pkg.sv @@
// Shared types, register codes and sine generator function for the binary keying modulator.
`timescale 1ns / 1ps
`default_nettype none

package bkm_pkg;

	localparam int PAT_W       = 10;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
	localparam logic [15:0] FIXED_AMP = 16'd512;

	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [2:0] {
		REG_MODULATION      = 3'd0,
		REG_SAMPLES_PER_BIT = 3'd1,
		REG_BIT_PATTERN     = 3'd2,
		REG_STEP_SPACE      = 3'd3,
		REG_STEP_MARK       = 3'd4,
		REG_AMP_SPACE       = 3'd5,
		REG_AMP_MARK        = 3'd6
	} bkm_reg_t;

	typedef enum logic [1:0] {
		MOD_ASK = 2'd0,
		MOD_FSK = 2'd1,
		MOD_PSK = 2'd2
	} bkm_mod_t;

	typedef struct packed {
		logic [1:0]       modulation;
		logic [15:0]      samples_per_bit;
		logic [PAT_W-1:0] bit_pattern;
		logic [31:0]      step_space;
		logic [31:0]      step_mark;
		logic [15:0]      amp_space;
		logic [15:0]      amp_mark;
	} bkm_cfg_t;

	typedef struct packed {
		logic       bit_val;
		logic [3:0] pos;
	} bkm_tag_t;

	localparam int TAG_W = $bits(bkm_tag_t);

	// First-quadrant sine, Q30 Taylor series evaluated at elaboration.
	function automatic logic [15:0] quarter_sine(logic [63:0] r, int shift);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		x  = (r * HALF_PI_Q30) >> shift;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 156);
		t  = Q30_ONE - (((x2 * t) >> 30) / 110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 6);
		s  = (x * t) >> 30;
		v  = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

`default_nettype wire

@@ src/binary_keying_modulator.sv @@
// Top level of the binary keying modulator: configuration registers, front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// ASK / FSK / PSK binary modulator. Each request pushed in produces one carrier sample
// (signed, amplitude Q8.8 times Q1.15 sine, shifted right by 8) together with the pattern
// bit and its position. One request is taken every clock while the queue is not full; a request
// passes from push through the four-entry queue between the phase front end and the
// registered sine ROM read, followed by the amplitude multiply into the result queue.
// Configuration is written through cfg_valid/cfg_ready, which is always ready; write only
// while no requests are in flight.
module binary_keying_modulator #(
	parameter int PATTERN_BITS    = 10,
	parameter int SINE_TABLE_BITS = 10,
	parameter int PHASE_BITS      = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               restart,
	output logic               empty,
	input  logic               pop,
	output logic signed [23:0] sample,
	output logic               current_bit,
	output logic [3:0]         bit_position,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import bkm_pkg::*;

	localparam int MID_W = SINE_TABLE_BITS + 16 + TAG_W;

	bkm_cfg_t                   cfg_q;
	logic                       accept;
	logic [SINE_TABLE_BITS-1:0] fe_idx;
	logic [15:0]                fe_amp;
	bkm_tag_t                   fe_tag;
	logic [MID_W-1:0]           mid_wr;
	logic [MID_W-1:0]           mid_rd;
	logic                       mid_empty;
	logic                       mid_pop;
	logic [FIFO_CNT_W-1:0]      mid_count;
	logic [SINE_TABLE_BITS-1:0] be_idx;
	logic [15:0]                be_amp;
	bkm_tag_t                   be_tag;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulation      <= 2'd1;
			cfg_q.samples_per_bit <= 16'd160;
			cfg_q.bit_pattern     <= 10'd199;
			cfg_q.step_space      <= 32'd21474836;
			cfg_q.step_mark       <= 32'd42949673;
			cfg_q.amp_space       <= 16'd174;
			cfg_q.amp_mark        <= 16'd11423;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULATION:      cfg_q.modulation      <= cfg_data[1:0];
				REG_SAMPLES_PER_BIT: cfg_q.samples_per_bit <= cfg_data[15:0];
				REG_BIT_PATTERN:     cfg_q.bit_pattern     <= cfg_data[PAT_W-1:0];
				REG_STEP_SPACE:      cfg_q.step_space      <= cfg_data;
				REG_STEP_MARK:       cfg_q.step_mark       <= cfg_data;
				REG_AMP_SPACE:       cfg_q.amp_space       <= cfg_data[15:0];
				REG_AMP_MARK:        cfg_q.amp_mark        <= cfg_data[15:0];
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	assign accept = push && !full;

	bkm_front #(
		.PATTERN_BITS   (PATTERN_BITS),
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.PHASE_BITS     (PHASE_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.accept (accept),
		.restart(restart),
		.tab_idx(fe_idx),
		.amp    (fe_amp),
		.tag    (fe_tag)
	);

	assign mid_wr = {fe_idx, fe_amp, fe_tag};

	bkm_fifo #(
		.WIDTH(MID_W)
	) u_mid_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(mid_wr),
		.pop    (mid_pop),
		.rd_data(mid_rd),
		.empty  (mid_empty),
		.full   (full),
		.count  (mid_count)
	);

	assign be_idx = mid_rd[MID_W-1 -: SINE_TABLE_BITS];
	assign be_amp = mid_rd[TAG_W +: 16];
	assign be_tag = mid_rd[TAG_W-1:0];

	bkm_back #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (!mid_empty),
		.in_idx      (be_idx),
		.in_amp      (be_amp),
		.in_tag      (be_tag),
		.in_pop      (mid_pop),
		.empty       (empty),
		.pop         (pop),
		.sample      (sample),
		.current_bit (current_bit),
		.bit_position(bit_position)
	);

	a_mid_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !mid_pop) |=> (mid_count != '0))
		else $error("accepted request missing from the queue");

endmodule

`default_nettype wire

@@ src/bkm_fifo.sv @@
// Small register-based queue with occupancy count.
`timescale 1ns / 1ps
`default_nettype none

module bkm_fifo #(
	parameter int WIDTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wr_data,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rd_data,
	output logic                           empty,
	output logic                           full,
	output logic [bkm_pkg::FIFO_CNT_W-1:0] count
);
	import bkm_pkg::*;

	logic [WIDTH-1:0]      mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  do_push;
	logic                  do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign count   = count_q;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/bkm_front.sv @@
// Front end: phase accumulators, bit timing and per-sample table index / amplitude selection.
`timescale 1ns / 1ps
`default_nettype none

module bkm_front #(
	parameter int PATTERN_BITS    = 10,
	parameter int SINE_TABLE_BITS = 10,
	parameter int PHASE_BITS      = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bkm_pkg::bkm_cfg_t          cfg,
	input  logic                       accept,
	input  logic                       restart,
	output logic [SINE_TABLE_BITS-1:0] tab_idx,
	output logic [15:0]                amp,
	output bkm_pkg::bkm_tag_t          tag
);
	import bkm_pkg::*;

	localparam int IDX_W = (PATTERN_BITS > 1) ? $clog2(PATTERN_BITS) : 1;

	logic [PHASE_BITS-1:0]      acc_space_q;
	logic [PHASE_BITS-1:0]      acc_mark_q;
	logic [15:0]                cnt_q;
	logic [IDX_W-1:0]           idx_q;

	logic [PHASE_BITS-1:0]      cur_space;
	logic [PHASE_BITS-1:0]      cur_mark;
	logic [15:0]                cur_cnt;
	logic [IDX_W-1:0]           cur_idx;
	logic [PHASE_BITS+31:0]     step_space_w;
	logic [PHASE_BITS+31:0]     step_mark_w;
	logic [IDX_W+3:0]           idx_w;
	logic [15:0]                pat16;
	logic                       bit_val;
	logic [SINE_TABLE_BITS-1:0] sp_idx;
	logic [SINE_TABLE_BITS-1:0] mk_idx;
	logic [15:0]                len;
	logic [16:0]                cnt_next;

	assign cur_space    = restart ? '0 : acc_space_q;
	assign cur_mark     = restart ? '0 : acc_mark_q;
	assign cur_cnt      = restart ? '0 : cnt_q;
	assign cur_idx      = restart ? '0 : idx_q;
	assign step_space_w = (PHASE_BITS + 32)'(cfg.step_space);
	assign step_mark_w  = (PHASE_BITS + 32)'(cfg.step_mark);

	assign idx_w   = (IDX_W + 4)'(cur_idx);
	assign pat16   = 16'(cfg.bit_pattern);
	assign bit_val = (idx_w < (IDX_W + 4)'(PAT_W)) ? pat16[idx_w[3:0]] : 1'b0;
	assign sp_idx  = cur_space[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign mk_idx  = cur_mark[PHASE_BITS-1 -: SINE_TABLE_BITS];

	assign tag.bit_val = bit_val;
	assign tag.pos     = idx_w[3:0];

	always_comb begin
		case (cfg.modulation)
			MOD_ASK: begin
				tab_idx = sp_idx;
				amp     = bit_val ? cfg.amp_mark : cfg.amp_space;
			end
			MOD_FSK: begin
				tab_idx = bit_val ? mk_idx : sp_idx;
				amp     = FIXED_AMP;
			end
			default: begin
				tab_idx = sp_idx ^ {bit_val, {(SINE_TABLE_BITS-1){1'b0}}};
				amp     = FIXED_AMP;
			end
		endcase
	end

	assign len      = (cfg.samples_per_bit == '0) ? 16'd1 : cfg.samples_per_bit;
	assign cnt_next = {1'b0, cur_cnt} + 17'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_space_q <= '0;
			acc_mark_q  <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
		end else if (accept) begin
			acc_space_q <= cur_space + step_space_w[PHASE_BITS-1:0];
			acc_mark_q  <= cur_mark + step_mark_w[PHASE_BITS-1:0];
			if (cnt_next >= {1'b0, len}) begin
				cnt_q <= '0;
				if (cur_idx == IDX_W'(PATTERN_BITS - 1)) begin
					idx_q <= '0;
				end else begin
					idx_q <= cur_idx + IDX_W'(1);
				end
			end else begin
				cnt_q <= cnt_next[15:0];
				idx_q <= cur_idx;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/bkm_back.sv @@
// Back end: sine ROM lookup, amplitude multiply and result queue.
`timescale 1ns / 1ps
`default_nettype none

module bkm_back #(
	parameter int SINE_TABLE_BITS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [SINE_TABLE_BITS-1:0] in_idx,
	input  logic [15:0]                in_amp,
	input  bkm_pkg::bkm_tag_t          in_tag,
	output logic                       in_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [23:0]         sample,
	output logic                       current_bit,
	output logic [3:0]                 bit_position
);
	import bkm_pkg::*;

	localparam int TABLE_LEN = 1 << SINE_TABLE_BITS;
	localparam int OUT_W     = 24 + TAG_W;

	typedef logic signed [15:0] rom_t [TABLE_LEN];

	function automatic rom_t build_rom();
		rom_t        rom;
		logic [63:0] quarter;
		logic [63:0] q;
		logic [63:0] r;
		logic [15:0] v;
		quarter = 64'd1 << (SINE_TABLE_BITS - 2);
		for (int k = 0; k < TABLE_LEN; k++) begin
			q = 64'(k) >> (SINE_TABLE_BITS - 2);
			r = 64'(k) & (quarter - 64'd1);
			v = q[0] ? quarter_sine(quarter - r, SINE_TABLE_BITS - 2)
			         : quarter_sine(r, SINE_TABLE_BITS - 2);
			rom[k] = q[1] ? -signed'(v) : signed'(v);
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic                  go;
	logic                  valid_s1;
	logic signed [15:0]    sine_s1;
	logic [15:0]           amp_s1;
	bkm_tag_t              tag_s1;
	logic signed [32:0]    prod;
	logic [OUT_W-1:0]      out_wr;
	logic [OUT_W-1:0]      out_rd;
	logic                  out_full;
	logic [FIFO_CNT_W-1:0] out_count;
	bkm_tag_t              out_tag;

	// issue only when the result queue has room for everything in flight
	assign go     = in_valid &&
	                (({1'b0, out_count} + (FIFO_CNT_W + 1)'(valid_s1))
	                 < (FIFO_CNT_W + 1)'(FIFO_DEPTH));
	assign in_pop = go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sine_s1 <= SINE_ROM[in_idx];
			amp_s1  <= in_amp;
			tag_s1  <= in_tag;
		end
	end

	assign prod   = $signed({1'b0, amp_s1}) * sine_s1;
	assign out_wr = {prod[31:8], tag_s1};

	bkm_fifo #(
		.WIDTH(OUT_W)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (valid_s1),
		.wr_data(out_wr),
		.pop    (pop),
		.rd_data(out_rd),
		.empty  (empty),
		.full   (out_full),
		.count  (out_count)
	);

	assign sample       = out_rd[OUT_W-1 -: 24];
	assign out_tag      = out_rd[TAG_W-1:0];
	assign current_bit  = out_tag.bit_val;
	assign bit_position = out_tag.pos;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_full)
		else $error("result queue written while full");

	a_issue_needs_req: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> in_valid)
		else $error("issue without a waiting request");

	a_issue_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(go && !pop) |-> ##2 !empty)
		else $error("issued request did not reach the result queue");

endmodule

`default_nettype wire
